// File: hdl/fvsm_pkg.sv
// Shared constants, control word type and microcode table of the four-voice sample mixer.
package fvsm_pkg;

    localparam int BUFFER_SAMPLES_DEF = 8192;
    localparam int VOICES_DEF         = 4;

    localparam int FUNC_W     = 2;
    localparam int VOICE_FW   = 2;
    localparam int INDEX_W    = 13;
    localparam int SAMPLE_W   = 16;
    localparam int LENGTH_W   = 14;
    localparam int DAC_W      = 12;
    localparam int GAIN_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int GAIN_REGS  = 4;

    // Product of a signed sample and an unsigned Q2.8 gain, and the scaled term.
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int TERM_W = PROD_W - 9;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 10'd256;
    localparam int MIX_MIN = -2047;
    localparam int MIX_MAX = 2047;
    localparam int DAC_MID = 2048;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PLAY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN0  = 3'd1;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_RD   = 3'd1;
    localparam step_t STEP_MUL  = 3'd2;
    localparam step_t STEP_ACC  = 3'd3;
    localparam step_t STEP_OUT  = 3'd4;

    // One microcode word. A jump to target is taken on an enabled tick when
    // dispatch is set, or while voices remain when br_more is set.
    typedef struct packed {
        logic  dispatch;
        logic  mem_rd;
        logic  mul;
        logic  acc;
        logic  br_more;
        logic  emit;
        step_t target;
        step_t next;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        w = '0;
        w.next   = STEP_IDLE;
        w.target = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                w.dispatch = 1'b1;
                w.target   = STEP_RD;
                w.next     = STEP_IDLE;
            end
            STEP_RD:
            begin
                w.mem_rd = 1'b1;
                w.next   = STEP_MUL;
            end
            STEP_MUL:
            begin
                w.mul  = 1'b1;
                w.next = STEP_ACC;
            end
            STEP_ACC:
            begin
                w.acc     = 1'b1;
                w.br_more = 1'b1;
                w.target  = STEP_RD;
                w.next    = STEP_OUT;
            end
            STEP_OUT:
            begin
                w.emit = 1'b1;
                w.next = STEP_IDLE;
            end
            default:
            begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hdl/four_voice_sample_mixer_unit.sv
// Top level of the four-voice sample mixer: sequencer, voice state, sample memory and output.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_stall    func, voice, index, sample, length
//   output    out        out_valid / out_stall  dac_code
//   config    in         cfg_write              cfg_index, cfg_data
//
// Write, play and stop words and ticks while disabled take one cycle each.
// An enabled tick runs the accept step, then read, multiply and accumulate
// for each voice in turn, then one output step. The single read port of the
// shared sample memory and the one multiplier are walked once per voice by
// the microcode sequencer.
// Reset clears voice positions and lengths, gains to unity and enable to zero;
// the sample memory is not cleared and holds nothing defined until written.
// A stalled result waits in the output register; the sequencer holds in its
// output step only when a second result would overwrite one still waiting.
module four_voice_sample_mixer_unit #(
    parameter int BUFFER_SAMPLES = fvsm_pkg::BUFFER_SAMPLES_DEF,
    parameter int VOICES         = fvsm_pkg::VOICES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fvsm_pkg::FUNC_W-1:0]         func,
    input  logic [fvsm_pkg::VOICE_FW-1:0]       voice,
    input  logic [fvsm_pkg::INDEX_W-1:0]        index,
    input  logic signed [fvsm_pkg::SAMPLE_W-1:0] sample,
    input  logic [fvsm_pkg::LENGTH_W-1:0]       length,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fvsm_pkg::DAC_W-1:0]          dac_code,

    input  logic                                cfg_write,
    input  logic [fvsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fvsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Each voice owns a power-of-two slice of the sample memory.
    localparam int ADDR_W    = $clog2(BUFFER_SAMPLES);
    localparam int VOICE_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int POS_W     = $clog2(BUFFER_SAMPLES + 1);
    localparam int MEM_DEPTH = VOICES * (2 ** ADDR_W);
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int MIX_W     = fvsm_pkg::TERM_W + VOICE_W;

    localparam logic signed [MIX_W-1:0] CLAMP_LO = MIX_W'(fvsm_pkg::MIX_MIN);
    localparam logic signed [MIX_W-1:0] CLAMP_HI = MIX_W'(fvsm_pkg::MIX_MAX);
    localparam logic signed [MIX_W-1:0] DAC_BIAS = MIX_W'(fvsm_pkg::DAC_MID);

    // Sequencer and voice state.
    fvsm_pkg::step_t             pc_reg, pc_next;
    logic [VOICE_W-1:0]          vcnt_reg, vcnt_next;
    logic [POS_W-1:0]            pos_reg  [VOICES];
    logic [POS_W-1:0]            pos_next [VOICES];
    logic [POS_W-1:0]            len_reg  [VOICES];
    logic [POS_W-1:0]            len_next [VOICES];
    logic [fvsm_pkg::GAIN_W-1:0] gain_reg  [VOICES];
    logic [fvsm_pkg::GAIN_W-1:0] gain_next [VOICES];
    logic                        enable_reg, enable_next;

    // Datapath.
    logic signed [MIX_W-1:0]              mix_reg, mix_next;
    logic signed [fvsm_pkg::SAMPLE_W-1:0] rdata_reg;
    logic signed [fvsm_pkg::PROD_W-1:0]   prod_reg;
    logic                                 out_valid_reg, out_valid_next;
    logic [fvsm_pkg::DAC_W-1:0]           dac_reg, dac_next;

    logic signed [fvsm_pkg::SAMPLE_W-1:0] sample_mem [MEM_DEPTH];

    fvsm_pkg::ctrl_word_t                 ctrl;
    logic                                 accept;
    logic                                 tick_go;
    logic                                 voice_ok;
    logic                                 wr_en;
    logic                                 active;
    logic                                 last_voice;
    logic                                 out_free;
    logic [VOICE_W-1:0]                   voice_idx;
    logic [VOICE_W-1:0]                   sel_idx;
    logic [POS_W-1:0]                     sel_pos;
    logic [POS_W-1:0]                     sel_len;
    logic [POS_W-1:0]                     len_sat;
    logic [MEM_AW-1:0]                    rd_addr;
    logic [MEM_AW-1:0]                    wr_addr;
    logic signed [fvsm_pkg::GAIN_W:0]     gain_s;
    logic signed [fvsm_pkg::PROD_W-1:0]   prod_adj;
    logic signed [fvsm_pkg::TERM_W-1:0]   term;
    logic signed [MIX_W-1:0]              half;
    logic signed [MIX_W-1:0]              clamped;
    logic signed [MIX_W-1:0]              biased;

    always_comb
    begin
        ctrl      = fvsm_pkg::ucode(pc_reg);
        in_stall  = !ctrl.dispatch;
        accept    = in_valid && !in_stall;
        tick_go   = accept && (func == fvsm_pkg::FUNC_TICK) && enable_reg;
        voice_ok  = int'(voice) < VOICES;
        voice_idx = VOICE_W'(voice);

        // Position and length have a single read index: the addressed voice while
        // idle, the voice being mixed while the program runs.
        sel_idx = ctrl.dispatch ? voice_idx : vcnt_reg;
        sel_pos = pos_reg[sel_idx];
        sel_len = len_reg[sel_idx];
        active  = sel_pos < sel_len;

        len_sat = (int'(length) > BUFFER_SAMPLES) ? POS_W'(BUFFER_SAMPLES) : POS_W'(length);

        rd_addr = (MEM_AW'(vcnt_reg) << ADDR_W) | MEM_AW'(sel_pos[ADDR_W-1:0]);
        wr_addr = (MEM_AW'(voice_idx) << ADDR_W) | MEM_AW'(ADDR_W'(index));
        wr_en   = accept && (func == fvsm_pkg::FUNC_WRITE) && voice_ok
                  && (int'(index) < BUFFER_SAMPLES);

        gain_s = signed'({1'b0, gain_reg[vcnt_reg]});

        // Divide by 256 truncating toward zero: bias negative products first.
        prod_adj = prod_reg + (prod_reg[fvsm_pkg::PROD_W-1] ?
                               fvsm_pkg::PROD_W'(255) : fvsm_pkg::PROD_W'(0));
        term     = prod_adj[fvsm_pkg::PROD_W-2:8];

        // Floor halving, clamp to the DAC range and shift to offset binary.
        half    = mix_reg >>> 1;
        clamped = (half < CLAMP_LO) ? CLAMP_LO : ((half > CLAMP_HI) ? CLAMP_HI : half);
        biased  = clamped + DAC_BIAS;

        last_voice = vcnt_reg == VOICE_W'(VOICES - 1);
        out_free   = !out_valid_reg || !out_stall;
    end

    // Next state of the sequencer, voice state and output register.
    always_comb
    begin
        pc_next        = ctrl.next;
        vcnt_next      = vcnt_reg;
        mix_next       = mix_reg;
        enable_next    = enable_reg;
        out_valid_next = out_valid_reg;
        dac_next       = dac_reg;
        for (int v = 0; v < VOICES; v++)
        begin
            pos_next[v]  = pos_reg[v];
            len_next[v]  = len_reg[v];
            gain_next[v] = gain_reg[v];
        end

        if (ctrl.dispatch)
        begin
            if (tick_go)
            begin
                pc_next   = ctrl.target;
                vcnt_next = '0;
                mix_next  = '0;
            end
        end

        if (accept && voice_ok)
        begin
            if (func == fvsm_pkg::FUNC_PLAY && length != '0)
            begin
                len_next[voice_idx] = len_sat;
                pos_next[voice_idx] = '0;
            end
            else if (func == fvsm_pkg::FUNC_STOP)
            begin
                pos_next[voice_idx] = sel_len;
            end
        end

        if (ctrl.acc)
        begin
            if (active)
            begin
                mix_next          = mix_reg + MIX_W'(term);
                pos_next[vcnt_reg] = sel_pos + POS_W'(1);
            end
            if (ctrl.br_more && !last_voice)
            begin
                pc_next   = ctrl.target;
                vcnt_next = vcnt_reg + VOICE_W'(1);
            end
            else
            begin
                vcnt_next = '0;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.emit)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                dac_next       = biased[fvsm_pkg::DAC_W-1:0];
            end
            else
            begin
                pc_next = pc_reg;
            end
        end

        if (cfg_write)
        begin
            if (cfg_index == fvsm_pkg::CFG_ENABLE)
            begin
                enable_next = cfg_data[0];
            end
            for (int v = 0; v < VOICES; v++)
            begin
                if (v < fvsm_pkg::GAIN_REGS
                    && int'(cfg_index) == int'(fvsm_pkg::CFG_GAIN0) + v)
                begin
                    gain_next[v] = cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= fvsm_pkg::STEP_IDLE;
            vcnt_reg      <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                pos_reg[v]  <= '0;
                len_reg[v]  <= '0;
                gain_reg[v] <= fvsm_pkg::GAIN_UNITY;
            end
        end
        else
        begin
            pc_reg        <= pc_next;
            vcnt_reg      <= vcnt_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
            for (int v = 0; v < VOICES; v++)
            begin
                pos_reg[v]  <= pos_next[v];
                len_reg[v]  <= len_next[v];
                gain_reg[v] <= gain_next[v];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
        dac_reg <= dac_next;
        if (ctrl.mul)
        begin
            prod_reg <= rdata_reg * gain_s;
        end
    end

    // Sample memory: one write port for write words, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[wr_addr] <= sample;
        end
        if (ctrl.mem_rd)
        begin
            rdata_reg <= sample_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign dac_code  = dac_reg;

    // An enabled tick always starts the per-voice program.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> pc_reg == fvsm_pkg::STEP_RD)
        else $error("enabled tick did not start the mixing program");

    // The voice counter is back at zero whenever the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == fvsm_pkg::STEP_IDLE |-> vcnt_reg == '0)
        else $error("voice counter not cleared at end of program");

    // A result appears only out of the output step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg) == fvsm_pkg::STEP_OUT)
        else $error("result raised outside the output step");

    // No voice ever plays past its length.
    for (genvar g = 0; g < VOICES; g++)
    begin : g_pos_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            pos_reg[g] <= len_reg[g])
            else $error("voice position beyond its length");
    end

endmodule
